### sv/lbsd_pkg.sv
// Shared types and fixed field widths for the LRU buffer slot directory.
`default_nettype none

package lbsd_pkg;

   // Fixed field widths of the stream and register ports
   localparam int POS_W           = 32;
   localparam int SLOT_FIELD_W    = 4;
   localparam int CAP_FIELD_W     = 5;
   localparam int CAP_RESET_VALUE = 16;

   // Request kind carried in req_tuser
   typedef enum logic {
      OP_ACCESS = 1'b0,
      OP_INSERT = 1'b1
   } lbsd_op_type;

   // What the directory does with the item in flight
   typedef struct packed {
      logic hit;    // key found: promote it
      logic fill;   // new key into the next free slot
      logic evict;  // new key replaces the least recent entry
   } lbsd_action_type;

endpackage

`default_nettype wire

### sv/lbsd_lookup.sv
// Parallel key match, LRU pick and slot decision for one item.
`default_nettype none

module lbsd_lookup import lbsd_pkg::*; #(
   parameter int SLOTS    = 16,
   parameter int KEY_BITS = 32,
   parameter int IDX_W    = $clog2(SLOTS),
   parameter int AGE_W    = $clog2(SLOTS),
   parameter int CNT_W    = $clog2(SLOTS + 1)
) (
   input  wire lbsd_op_type                    op,
   input  wire logic [KEY_BITS-1:0]            key,
   input  wire logic [SLOTS-1:0][KEY_BITS-1:0] entry_key,
   input  wire logic [SLOTS-1:0]               entry_valid,
   input  wire logic [SLOTS-1:0][AGE_W-1:0]    entry_age,
   input  wire logic [CNT_W-1:0]               fill_count,
   input  wire logic [CNT_W-1:0]               capacity,
   output lbsd_action_type                     action,
   output logic [IDX_W-1:0]                    slot_idx
);

   logic [SLOTS-1:0] match_vec;
   logic [SLOTS-1:0] lru_vec;
   logic [AGE_W-1:0] lru_age;
   logic [IDX_W-1:0] hit_idx;
   logic [IDX_W-1:0] lru_idx;
   logic             any_hit;
   logic             room;

   // Ranks of valid entries are always 0..fill-1, so the LRU entry has rank fill-1
   assign lru_age = AGE_W'(fill_count - CNT_W'(1));

   // One comparator and one rank compare per entry
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i] = entry_valid[i] && (entry_key[i] == key);
         lru_vec[i]   = entry_valid[i] && (entry_age[i] == lru_age);
      end
   end

   // Both vectors are one-hot at most: OR-encode them
   always_comb begin
      hit_idx = '0;
      lru_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (match_vec[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
         if (lru_vec[i]) begin
            lru_idx = lru_idx | IDX_W'(i);
         end
      end
   end

   assign any_hit = |match_vec;
   assign room    = fill_count < capacity;

   // Decision
   always_comb begin
      action.hit   = any_hit;
      action.fill  = !any_hit && (op == OP_INSERT) && room;
      action.evict = !any_hit && (op == OP_INSERT) && !room;
      priority if (action.hit) begin
         slot_idx = hit_idx;
      end else if (action.fill) begin
         slot_idx = fill_count[IDX_W-1:0];
      end else if (action.evict) begin
         slot_idx = lru_idx;
      end else begin
         slot_idx = '0;
      end
   end

endmodule

`default_nettype wire

### sv/lbsd_state.sv
// Directory storage: keys, valid bits, recency ranks, fill count and capacity.
`default_nettype none

module lbsd_state import lbsd_pkg::*; #(
   parameter int SLOTS    = 16,
   parameter int KEY_BITS = 32,
   parameter int IDX_W    = $clog2(SLOTS),
   parameter int AGE_W    = $clog2(SLOTS),
   parameter int CNT_W    = $clog2(SLOTS + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           commit,
   input  wire lbsd_action_type                action,
   input  wire logic [IDX_W-1:0]               slot_idx,
   input  wire logic [KEY_BITS-1:0]            key,
   input  wire logic                           cfg_write,
   input  wire logic [CAP_FIELD_W-1:0]         cfg_value,
   output logic [SLOTS-1:0][KEY_BITS-1:0]      entry_key,
   output logic [SLOTS-1:0]                    entry_valid,
   output logic [SLOTS-1:0][AGE_W-1:0]         entry_age,
   output logic [CNT_W-1:0]                    fill_count,
   output logic [CNT_W-1:0]                    capacity
);

   localparam int CAP_RESET = (SLOTS < CAP_RESET_VALUE) ? SLOTS : CAP_RESET_VALUE;

   logic [SLOTS-1:0][KEY_BITS-1:0] entry_key_ff;
   logic [SLOTS-1:0]               entry_valid_ff, entry_valid_in;
   logic [SLOTS-1:0][AGE_W-1:0]    entry_age_ff, entry_age_in;
   logic [CNT_W-1:0]               fill_count_ff, fill_count_in;
   logic [CNT_W-1:0]               capacity_ff, capacity_in;
   logic [AGE_W-1:0]               old_age;
   logic                           promote;
   logic                           touch;

   assign old_age = entry_age_ff[slot_idx];
   assign promote = commit && (action.hit || action.evict);
   assign touch   = commit && (action.hit || action.evict || action.fill);

   // Recency update: fill ages every valid entry, promote ages the younger ones
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         entry_age_in[i]   = entry_age_ff[i];
         entry_valid_in[i] = entry_valid_ff[i];
         if (commit && action.fill && entry_valid_ff[i]) begin
            entry_age_in[i] = entry_age_ff[i] + AGE_W'(1);
         end
         if (promote && entry_valid_ff[i] && (entry_age_ff[i] < old_age)) begin
            entry_age_in[i] = entry_age_ff[i] + AGE_W'(1);
         end
         if (touch && (IDX_W'(i) == slot_idx)) begin
            entry_age_in[i]   = '0;
            entry_valid_in[i] = 1'b1;
         end
      end
   end

   // Fill count and capacity (capacity taken only while empty, clamped to 1..SLOTS)
   always_comb begin
      fill_count_in = fill_count_ff;
      capacity_in   = capacity_ff;
      if (commit && action.fill) begin
         fill_count_in = fill_count_ff + CNT_W'(1);
      end
      if (cfg_write && (fill_count_ff == '0)) begin
         priority if (cfg_value == '0) begin
            capacity_in = CNT_W'(1);
         end else if (32'(cfg_value) > SLOTS) begin
            capacity_in = CNT_W'(SLOTS);
         end else begin
            capacity_in = CNT_W'(cfg_value);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         entry_age_ff   <= '0;
         fill_count_ff  <= '0;
         capacity_ff    <= CNT_W'(CAP_RESET);
      end else begin
         entry_valid_ff <= entry_valid_in;
         entry_age_ff   <= entry_age_in;
         fill_count_ff  <= fill_count_in;
         capacity_ff    <= capacity_in;
      end
   end

   // Key store: written on fill or replacement, no reset
   always_ff @(posedge clock) begin
      if (commit && (action.fill || action.evict)) begin
         entry_key_ff[slot_idx] <= key;
      end
   end

   assign entry_key   = entry_key_ff;
   assign entry_valid = entry_valid_ff;
   assign entry_age   = entry_age_ff;
   assign fill_count  = fill_count_ff;
   assign capacity    = capacity_ff;

   // Fill count tracks the valid bits
   a_fill_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(entry_valid_ff) == int'(fill_count_ff))
      else $error("fill count does not match valid entries");

   // Never more entries than the capacity
   a_fill_within_cap: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= capacity_ff)
      else $error("fill count above capacity");

   // Replacement only when the directory is full
   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      commit && action.evict |-> fill_count_ff == capacity_ff)
      else $error("eviction with free slots left");

endmodule

`default_nettype wire

### sv/lru_buffer_slot_directory.sv
// Top level: input register, directory lookup and update, result register.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | tuser: opcode; tdata: file_position
//   rsp     | out | rsp_tvalid/rsp_tready  | tuser: hit, evicted; tdata: buffer_slot
//   csr     | in  | csr_tvalid/csr_tready  | tdata: capacity
//
// One item per cycle while the result channel does not stall; an accepted request
// waits in the input register and moves on into the result register. Each item is
// decided and committed to the directory as it moves; the next item sees its update.
// Reset empties the directory at once and sets capacity to 16 (or SLOTS if smaller).
// A stalled result holds the item behind it in the input register; csr_tready
// is always high and a capacity write is dropped unless the directory is empty.
`default_nettype none

module lru_buffer_slot_directory import lbsd_pkg::*; #(
   parameter int SLOTS    = 16,
   parameter int KEY_BITS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] file_position
   input  wire logic [0:0]  req_tuser,   // [0] opcode
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [3:0] buffer_slot, [7:4] zero
   output logic [1:0]      rsp_tuser,    // [0] hit, [1] evicted
   input  wire logic       csr_tvalid,
   output logic            csr_tready,
   input  wire logic [7:0] csr_tdata     // [4:0] capacity, [7:5] unused
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int AGE_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int KEXT_W = (KEY_BITS > POS_W) ? KEY_BITS : POS_W;
   localparam int SEXT_W = (IDX_W > SLOT_FIELD_W) ? IDX_W : SLOT_FIELD_W;

   logic                           req_valid_ff, req_valid_in;
   lbsd_op_type                    req_op_ff;
   logic [KEY_BITS-1:0]            req_key_ff;
   logic [KEXT_W-1:0]              key_ext;
   logic                           advance;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff;
   logic                           rsp_evicted_ff;
   logic [SLOT_FIELD_W-1:0]        rsp_slot_ff;

   lbsd_action_type                action;
   logic [IDX_W-1:0]               slot_idx;
   logic [SEXT_W-1:0]              slot_ext;
   logic [SLOTS-1:0][KEY_BITS-1:0] entry_key;
   logic [SLOTS-1:0]               entry_valid;
   logic [SLOTS-1:0][AGE_W-1:0]    entry_age;
   logic [CNT_W-1:0]               fill_count;
   logic [CNT_W-1:0]               capacity;

   // Handshake: advance when the result register is free or being drained
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !req_valid_ff || advance;
   assign req_valid_in = req_tready ? req_tvalid : req_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign key_ext      = KEXT_W'(req_tdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_tready) begin
         req_op_ff  <= lbsd_op_type'(req_tuser[0]);
         req_key_ff <= key_ext[KEY_BITS-1:0];
      end
   end

   lbsd_lookup #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W),
      .AGE_W    (AGE_W),
      .CNT_W    (CNT_W)
   ) u_lookup (
      .op          (req_op_ff),
      .key         (req_key_ff),
      .entry_key   (entry_key),
      .entry_valid (entry_valid),
      .entry_age   (entry_age),
      .fill_count  (fill_count),
      .capacity    (capacity),
      .action      (action),
      .slot_idx    (slot_idx)
   );

   lbsd_state #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W),
      .AGE_W    (AGE_W),
      .CNT_W    (CNT_W)
   ) u_state (
      .clock       (clock),
      .reset       (reset),
      .commit      (advance),
      .action      (action),
      .slot_idx    (slot_idx),
      .key         (req_key_ff),
      .cfg_write   (csr_tvalid && csr_tready),
      .cfg_value   (csr_tdata[CAP_FIELD_W-1:0]),
      .entry_key   (entry_key),
      .entry_valid (entry_valid),
      .entry_age   (entry_age),
      .fill_count  (fill_count),
      .capacity    (capacity)
   );

   // Result register payload
   assign slot_ext = SEXT_W'(slot_idx);

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff     <= action.hit;
         rsp_evicted_ff <= action.evict;
         rsp_slot_ff    <= slot_ext[SLOT_FIELD_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - SLOT_FIELD_W){1'b0}}, rsp_slot_ff};
   assign rsp_tuser  = {rsp_evicted_ff, rsp_hit_ff};
   assign csr_tready = 1'b1;

   // A hit never replaces an entry
   a_hit_not_evicted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("result flags both hit and eviction");

   // An item only moves on into a free or draining result register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !advance)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### tb/sv/lru_buffer_slot_directory_tb.sv
// Self-checking testbench for the LRU buffer slot directory: stream stimulus, scoreboard.
`default_nettype none

module lru_buffer_slot_directory_tb import lbsd_pkg::*;;

   localparam int DIR_SLOTS   = 16;
   localparam int POOL_SIZE   = 24;
   localparam int HOLD_CYCLES = 80;

   // One directory answer as it should appear on the result channel
   typedef struct packed {
      logic                    hit;
      logic [SLOT_FIELD_W-1:0] slot;
      logic                    evicted;
   } slot_result_type;

   // Shadow directory plus queue of answers still owed by the block
   class slot_directory_scoreboard_type;
      logic [POS_W-1:0] key_q [DIR_SLOTS];
      bit               valid_q [DIR_SLOTS];
      int               age_q [DIR_SLOTS];
      int               fill;
      int               cap;
      slot_result_type  answer_q [$];
      int               errors;
      int               checked;
      int               hits;
      int               fills;
      int               evictions;
      int               misses;

      function new();
         for (int i = 0; i < DIR_SLOTS; i++) begin
            key_q[i]   = '0;
            valid_q[i] = 1'b0;
            age_q[i]   = 0;
         end
         fill      = 0;
         cap       = CAP_RESET_VALUE;
         errors    = 0;
         checked   = 0;
         hits      = 0;
         fills     = 0;
         evictions = 0;
         misses    = 0;
      endfunction

      // Entry becomes most recent; younger valid entries age by one
      function void promote_entry(int idx);
         int old_age;
         old_age = age_q[idx];
         for (int i = 0; i < DIR_SLOTS; i++)
            if (valid_q[i] && i != idx && age_q[i] < old_age)
               age_q[i] = age_q[i] + 1;
         age_q[idx] = 0;
      endfunction

      function int find_entry(logic [POS_W-1:0] key);
         for (int i = 0; i < DIR_SLOTS; i++)
            if (valid_q[i] && key_q[i] == key)
               return i;
         return -1;
      endfunction

      // Capacity transfer: taken only while the directory is empty, clamped to 1..16
      function void note_capacity(logic [7:0] wdata);
         int v;
         v = int'(wdata[CAP_FIELD_W-1:0]);
         if (fill != 0)
            return;
         if (v < 1)
            v = 1;
         if (v > DIR_SLOTS)
            v = DIR_SLOTS;
         cap = v;
      endfunction

      // Request transfer: update the shadow directory and queue its answer
      function void note_request(lbsd_op_type op, logic [POS_W-1:0] key);
         slot_result_type res;
         int              found;
         int              oldest;
         bit              any;
         res   = '0;
         found = find_entry(key);
         if (found >= 0) begin
            res.hit  = 1'b1;
            res.slot = found[SLOT_FIELD_W-1:0];
            promote_entry(found);
            hits++;
         end else if (op == OP_INSERT) begin
            if (fill < cap && fill < DIR_SLOTS) begin
               res.slot = fill[SLOT_FIELD_W-1:0];
               for (int i = 0; i < DIR_SLOTS; i++)
                  if (valid_q[i])
                     age_q[i] = age_q[i] + 1;
               key_q[fill]   = key;
               valid_q[fill] = 1'b1;
               age_q[fill]   = 0;
               fill++;
               fills++;
            end else begin
               oldest = 0;
               any    = 1'b0;
               for (int i = 0; i < DIR_SLOTS; i++)
                  if (valid_q[i] && (!any || age_q[i] > age_q[oldest])) begin
                     oldest = i;
                     any    = 1'b1;
                  end
               res.slot      = oldest[SLOT_FIELD_W-1:0];
               key_q[oldest] = key;
               if (any) begin
                  promote_entry(oldest);
                  res.evicted = 1'b1;
                  evictions++;
               end else begin
                  valid_q[oldest] = 1'b1;
                  age_q[oldest]   = 0;
                  fill            = 1;
               end
            end
         end else begin
            misses++;
         end
         answer_q.push_back(res);
      endfunction

      // Result transfer: compare with the oldest queued answer
      function void check_result(logic [7:0] tdata, logic [1:0] tuser);
         slot_result_type want;
         if (answer_q.size() == 0) begin
            $display("%0t: unexpected result, tdata %h tuser %b", $time, tdata, tuser);
            errors++;
            return;
         end
         want = answer_q.pop_front();
         checked++;
         if (tuser[0] !== want.hit) begin
            $display("%0t: hit mismatch, expected %0d actual %b", $time, want.hit, tuser[0]);
            errors++;
         end
         if (tdata !== {4'b0000, want.slot}) begin
            $display("%0t: buffer_slot mismatch, expected %0d actual %h",
                     $time, want.slot, tdata);
            errors++;
         end
         if (tuser[1] !== want.evicted) begin
            $display("%0t: evicted mismatch, expected %0d actual %b",
                     $time, want.evicted, tuser[1]);
            errors++;
         end
      endfunction

      function int pending();
         return answer_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_tvalid;
   logic        csr_tready;
   logic [7:0]  csr_tdata;

   slot_directory_scoreboard_type sb = new();

   bit               req_idle_on;
   bit               rsp_idle_on;
   bit               hold_off_pending;
   logic [POS_W-1:0] key_pool [POOL_SIZE];

   lru_buffer_slot_directory DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] file_position
      .req_tuser  (req_tuser),   // [0] opcode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [3:0] buffer_slot, [7:4] zero
      .rsp_tuser  (rsp_tuser),   // [0] hit, [1] evicted
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)    // [4:0] capacity, [7:5] unused
   );

   // Clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Monitor: every transfer on the three channels goes to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_tvalid && csr_tready)
            sb.note_capacity(csr_tdata);
         if (req_tvalid && req_tready)
            sb.note_request(lbsd_op_type'(req_tuser[0]), req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Result side: random stall bursts and one long hold-off on request
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Present one request and hold it until transfer; valid stays high afterwards
   task automatic send_item(input lbsd_op_type op, input logic [POS_W-1:0] pos);
      req_tvalid <= 1'b1;
      req_tdata  <= pos;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   // Random gap on the request side
   task automatic req_gap();
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Drop valid and wait for every owed result plus the pipeline depth
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [7:0] wdata);
      csr_tvalid <= 1'b1;
      csr_tdata  <= wdata;
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly pooled keys so hits and evictions happen; some near misses and noise
   function automatic logic [POS_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 90)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'h1 << $urandom_range(0, 31));
      else
         return $urandom();
   endfunction

   task automatic random_items(input int count);
      for (int n = 0; n < count; n++) begin
         req_gap();
         send_item(lbsd_op_type'($urandom_range(0, 1)), pick_key());
      end
   endtask

   // Main sequence
   initial begin
      int run_cap;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = '0;
      csr_tvalid       = 1'b0;
      csr_tdata        = '0;
      req_idle_on      = 1'b1;
      rsp_idle_on      = 1'b1;
      hold_off_pending = 1'b0;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = $urandom();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty directory: capacity clamps at both ends, access misses
      csr_write(8'h00);
      send_item(OP_ACCESS, 32'h0000_0000);
      send_item(OP_ACCESS, 32'hFFFF_FFFF);
      wait_drained();
      csr_write(8'hFF);
      send_item(OP_ACCESS, 32'h1234_5678);
      wait_drained();
      run_cap = $urandom_range(1, 16);
      csr_write({3'b010, run_cap[4:0]});

      // Fill, refresh of a present key, hit, miss, then fill past capacity
      send_item(OP_INSERT, 32'h0000_0000);
      send_item(OP_INSERT, 32'hFFFF_FFFF);
      send_item(OP_INSERT, 32'h0000_0000);
      send_item(OP_ACCESS, 32'hFFFF_FFFF);
      send_item(OP_ACCESS, 32'hDEAD_BEEF);
      for (int i = 2; i < 18; i++)
         send_item(OP_INSERT, key_pool[i]);
      wait_drained();

      // Capacity write while entries are held is dropped
      csr_write(8'h03);

      random_items(300);

      // Long result hold-off while requests keep coming
      hold_off_pending = 1'b1;
      for (int n = 0; n < 40; n++)
         send_item(lbsd_op_type'($urandom_range(0, 1)), pick_key());
      wait_drained();
      csr_write(8'h10);

      random_items(400);

      // Tail at full rate on both sides
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      random_items(180);

      wait_drained();
      repeat (10) @(posedge clock);

      $display("Checked %0d results with capacity %0d: %0d hits, %0d fills, %0d evictions,",
               sb.checked, sb.cap, sb.hits, sb.fills, sb.evictions);
      $display("%0d access misses; capacity written at both limits and while occupied.",
               sb.misses);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("lru_buffer_slot_directory_tb: done, clean");
      end else begin
         $display("lru_buffer_slot_directory_tb: done, errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("Timeout with %0d results outstanding", sb.pending());
      $display("lru_buffer_slot_directory_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
